// ----- rtl/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg: shared widths, types and helpers for point_segment_distance_3d
// Coordinate, product and wide-word widths, pipeline depths, stage structs.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int MAG_W    = COORD_W;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int SQ_W     = PROD_W + 2;
    localparam int WIDE_W   = 2 * SQ_W;
    localparam int HALF_W   = SQ_W / 2;
    localparam int OUT_W    = SQ_W / 2;
    localparam int REM_W    = OUT_W + 2;
    localparam int FRONT_LAT = 7;
    localparam int DIV_LAT  = SQ_W + 1;
    localparam int SQRT_LAT = OUT_W + 1;

    // how the projection parameter falls
    typedef struct packed {
        logic degen;
        logic pre_start;
        logic past;
    } seg_class_t;

    // front end results handed to the dividers
    typedef struct packed {
        seg_class_t          cls;
        logic [SQ_W-1:0]     l2;
        logic [SQ_W-1:0]     pv2;
        logic [SQ_W-1:0]     pw2;
        logic [WIDE_W-1:0]   d2;
        logic [WIDE_W-1:0]   num;
    } front_t;

    // data that rides alongside the dividers
    typedef struct packed {
        seg_class_t          cls;
        logic [SQ_W-1:0]     l2;
        logic [SQ_W-1:0]     pv2;
        logic [SQ_W-1:0]     pw2;
    } side_t;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] a;
        a = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return a[MAG_W-1:0];
    endfunction

endpackage

// ----- rtl/psd_front.sv -----
// ----------------------------------------------------------------------------
// psd_front: differences, squares, dot product and wide products
// Seven register stages from the coordinates to d2 = dot^2 and
// num = |P-V|^2 * l2 - dot^2, with the projection class.
// ----------------------------------------------------------------------------
module psd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [psd_pkg::COORD_W-1:0]  point_x,
    input  logic signed [psd_pkg::COORD_W-1:0]  point_y,
    input  logic signed [psd_pkg::COORD_W-1:0]  point_z,
    input  logic signed [psd_pkg::COORD_W-1:0]  start_x,
    input  logic signed [psd_pkg::COORD_W-1:0]  start_y,
    input  logic signed [psd_pkg::COORD_W-1:0]  start_z,
    input  logic signed [psd_pkg::COORD_W-1:0]  end_x,
    input  logic signed [psd_pkg::COORD_W-1:0]  end_y,
    input  logic signed [psd_pkg::COORD_W-1:0]  end_z,
    output logic                                out_valid,
    output psd_pkg::front_t                     out_data
);

    localparam int DW = psd_pkg::DIFF_W;
    localparam int SW = psd_pkg::SQ_W;
    localparam int WW = psd_pkg::WIDE_W;
    localparam int HW = psd_pkg::HALF_W;
    localparam int PW = psd_pkg::PROD_W;

    logic signed [psd_pkg::COORD_W-1:0] p_in [3];
    logic signed [psd_pkg::COORD_W-1:0] v_in [3];
    logic signed [psd_pkg::COORD_W-1:0] w_in [3];

    logic [psd_pkg::FRONT_LAT-1:0] vld_reg;

    logic signed [DW-1:0] pv_reg [3];
    logic signed [DW-1:0] wv_reg [3];
    logic signed [DW-1:0] pw_reg [3];

    logic [PW-1:0] dp_reg [3];
    logic [2:0]    dneg_reg;
    logic [PW-1:0] wq_reg [3];
    logic [PW-1:0] pq_reg [3];
    logic [PW-1:0] eq_reg [3];

    logic [SW-1:0] l2_3_reg, pv2_3_reg, pw2_3_reg, pos_reg, neg_reg;
    logic [SW-1:0] pos_next, neg_next;

    psd_pkg::seg_class_t cls4_reg, cls5_reg, cls6_reg, cls7_reg;
    logic [SW-1:0] dotm_reg, l2_4_reg, pv2_4_reg, pw2_4_reg;
    logic [SW-1:0] dotm_next;

    logic [SW-1:0] l2_5_reg, pv2_5_reg, pw2_5_reg;
    logic [2*HW-1:0] dll_reg, dlh_reg, dhh_reg, pll_reg, plh_reg, phl_reg, phh_reg;

    logic [SW-1:0] l2_6_reg, pv2_6_reg, pw2_6_reg;
    logic [WW-1:0] d2_6_reg, prod_reg;

    logic [SW-1:0] l2_7_reg, pv2_7_reg, pw2_7_reg;
    logic [WW-1:0] d2_7_reg, num_reg;

    always_comb
    begin
        p_in[0] = point_x;  p_in[1] = point_y;  p_in[2] = point_z;
        v_in[0] = start_x;  v_in[1] = start_y;  v_in[2] = start_z;
        w_in[0] = end_x;    w_in[1] = end_y;    w_in[2] = end_z;
    end

    // advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[psd_pkg::FRONT_LAT-2:0], in_valid};
    end

    // stage 1: coordinate differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pv_reg[k] <= DW'(p_in[k]) - DW'(v_in[k]);
                wv_reg[k] <= DW'(w_in[k]) - DW'(v_in[k]);
                pw_reg[k] <= DW'(p_in[k]) - DW'(w_in[k]);
            end
        end
    end

    // stage 2: magnitude products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dp_reg[k]   <= PW'(psd_pkg::mag_of(pv_reg[k]))
                               * PW'(psd_pkg::mag_of(wv_reg[k]));
                dneg_reg[k] <= pv_reg[k][DW-1] ^ wv_reg[k][DW-1];
                wq_reg[k]   <= PW'(psd_pkg::mag_of(wv_reg[k]))
                               * PW'(psd_pkg::mag_of(wv_reg[k]));
                pq_reg[k]   <= PW'(psd_pkg::mag_of(pv_reg[k]))
                               * PW'(psd_pkg::mag_of(pv_reg[k]));
                eq_reg[k]   <= PW'(psd_pkg::mag_of(pw_reg[k]))
                               * PW'(psd_pkg::mag_of(pw_reg[k]));
            end
        end
    end

    // stage 3: sum squares and split dot product by sign
    always_comb
    begin
        pos_next = '0;
        neg_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (dneg_reg[k])
                neg_next = neg_next + SW'(dp_reg[k]);
            else
                pos_next = pos_next + SW'(dp_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_3_reg  <= SW'(wq_reg[0]) + SW'(wq_reg[1]) + SW'(wq_reg[2]);
            pv2_3_reg <= SW'(pq_reg[0]) + SW'(pq_reg[1]) + SW'(pq_reg[2]);
            pw2_3_reg <= SW'(eq_reg[0]) + SW'(eq_reg[1]) + SW'(eq_reg[2]);
            pos_reg   <= pos_next;
            neg_reg   <= neg_next;
        end
    end

    // stage 4: classify the projection
    assign dotm_next = pos_reg - neg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls4_reg.degen     <= (l2_3_reg == '0);
            cls4_reg.pre_start <= (pos_reg <= neg_reg);
            cls4_reg.past      <= (dotm_next >= l2_3_reg);
            dotm_reg           <= dotm_next;
            l2_4_reg           <= l2_3_reg;
            pv2_4_reg          <= pv2_3_reg;
            pw2_4_reg          <= pw2_3_reg;
        end
    end

    // stage 5: half-width partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dll_reg <= (2*HW)'(dotm_reg[HW-1:0]) * (2*HW)'(dotm_reg[HW-1:0]);
            dlh_reg <= (2*HW)'(dotm_reg[HW-1:0]) * (2*HW)'(dotm_reg[SW-1:HW]);
            dhh_reg <= (2*HW)'(dotm_reg[SW-1:HW]) * (2*HW)'(dotm_reg[SW-1:HW]);
            pll_reg <= (2*HW)'(pv2_4_reg[HW-1:0]) * (2*HW)'(l2_4_reg[HW-1:0]);
            plh_reg <= (2*HW)'(pv2_4_reg[HW-1:0]) * (2*HW)'(l2_4_reg[SW-1:HW]);
            phl_reg <= (2*HW)'(pv2_4_reg[SW-1:HW]) * (2*HW)'(l2_4_reg[HW-1:0]);
            phh_reg <= (2*HW)'(pv2_4_reg[SW-1:HW]) * (2*HW)'(l2_4_reg[SW-1:HW]);
            cls5_reg  <= cls4_reg;
            l2_5_reg  <= l2_4_reg;
            pv2_5_reg <= pv2_4_reg;
            pw2_5_reg <= pw2_4_reg;
        end
    end

    // stage 6: combine partials into wide products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_6_reg <= (WW'(dhh_reg) << (2*HW)) + (WW'(dlh_reg) << (HW+1)) + WW'(dll_reg);
            prod_reg <= (WW'(phh_reg) << (2*HW)) + ((WW'(plh_reg) + WW'(phl_reg)) << HW)
                        + WW'(pll_reg);
            cls6_reg  <= cls5_reg;
            l2_6_reg  <= l2_5_reg;
            pv2_6_reg <= pv2_5_reg;
            pw2_6_reg <= pw2_5_reg;
        end
    end

    // stage 7: squared perpendicular distance times l2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg   <= prod_reg - d2_6_reg;
            d2_7_reg  <= d2_6_reg;
            cls7_reg  <= cls6_reg;
            l2_7_reg  <= l2_6_reg;
            pv2_7_reg <= pv2_6_reg;
            pw2_7_reg <= pw2_6_reg;
        end
    end

    assign out_valid     = vld_reg[psd_pkg::FRONT_LAT-1];
    assign out_data.cls  = cls7_reg;
    assign out_data.l2   = l2_7_reg;
    assign out_data.pv2  = pv2_7_reg;
    assign out_data.pw2  = pw2_7_reg;
    assign out_data.d2   = d2_7_reg;
    assign out_data.num  = num_reg;

endmodule

// ----- rtl/psd_div.sv -----
// ----------------------------------------------------------------------------
// psd_div: pipelined restoring divider
// Divides a wide numerator by a divisor, one quotient bit per stage. The
// quotient must fit in the divisor width (numerator < divisor << SQ_W).
// ----------------------------------------------------------------------------
module psd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [psd_pkg::WIDE_W-1:0]    num,
    input  logic [psd_pkg::SQ_W-1:0]      den,
    output logic                          out_valid,
    output logic [psd_pkg::SQ_W-1:0]      quo
);

    localparam int SW    = psd_pkg::SQ_W;
    localparam int STEPS = psd_pkg::SQ_W;

    logic [STEPS:0]   vld_reg;
    logic [SW-1:0]    rem_reg [STEPS+1];
    logic [SW-1:0]    lo_reg  [STEPS+1];
    logic [SW-1:0]    quo_reg [STEPS+1];
    logic [SW-1:0]    den_reg [STEPS+1];

    logic [SW:0]      shifted [STEPS];
    logic             ge      [STEPS];

    // trial subtract per stage
    always_comb
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            shifted[i] = {rem_reg[i], lo_reg[i][SW-1]};
            ge[i]      = (shifted[i] >= {1'b0, den_reg[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STEPS-1:0], in_valid};
    end

    // load, then shift one numerator bit in per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num[psd_pkg::WIDE_W-1:SW];
            lo_reg[0]  <= num[SW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            for (int i = 0; i < STEPS; i++)
            begin
                rem_reg[i+1] <= ge[i] ? SW'(shifted[i] - {1'b0, den_reg[i]})
                                      : shifted[i][SW-1:0];
                lo_reg[i+1]  <= {lo_reg[i][SW-2:0], 1'b0};
                quo_reg[i+1] <= {quo_reg[i][SW-2:0], ge[i]};
                den_reg[i+1] <= den_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign quo       = quo_reg[STEPS];

endmodule

// ----- rtl/psd_sqrt.sv -----
// ----------------------------------------------------------------------------
// psd_sqrt: pipelined integer square root
// Floor square root, one root bit per stage from the top pair of bits down.
// ----------------------------------------------------------------------------
module psd_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [psd_pkg::SQ_W-1:0]      radicand,
    output logic                          out_valid,
    output logic [psd_pkg::OUT_W-1:0]     root
);

    localparam int SW    = psd_pkg::SQ_W;
    localparam int OW    = psd_pkg::OUT_W;
    localparam int RW    = psd_pkg::REM_W;
    localparam int STEPS = psd_pkg::OUT_W;

    logic [STEPS:0]   vld_reg;
    logic [SW-1:0]    x_reg    [STEPS+1];
    logic [RW-1:0]    rem_reg  [STEPS+1];
    logic [OW-1:0]    root_reg [STEPS+1];

    logic [RW+1:0]    shifted  [STEPS];
    logic [RW+1:0]    trial    [STEPS];
    logic             ge       [STEPS];

    // trial subtract per stage
    always_comb
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            shifted[i] = {rem_reg[i], x_reg[i][SW-1 -: 2]};
            trial[i]   = (RW+2)'({root_reg[i], 2'b01});
            ge[i]      = (shifted[i] >= trial[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STEPS-1:0], in_valid};
    end

    // load, then take two radicand bits per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= radicand;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            for (int i = 0; i < STEPS; i++)
            begin
                x_reg[i+1]    <= {x_reg[i][SW-3:0], 2'b00};
                rem_reg[i+1]  <= ge[i] ? RW'(shifted[i] - trial[i]) : RW'(shifted[i]);
                root_reg[i+1] <= {root_reg[i][OW-2:0], ge[i]};
            end
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign root      = root_reg[STEPS];

    // remainder of a finished root never exceeds twice the root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STEPS] |-> ((RW+1)'(rem_reg[STEPS]) <= (RW+1)'({root_reg[STEPS], 1'b0})))
        else $error("sqrt remainder out of range");

endmodule

// ----- rtl/point_segment_distance_3d.sv -----
// Path: input transfer to result through the front end, the dividers, the
//   select register and the square roots.
// Throughput: one item per cycle; every stage advances together unless the
//   output register holds a result under stall.
// Reset: rst_n clears all valid bits asynchronously; no clearing pass.
// ----------------------------------------------------------------------------
// point_segment_distance_3d: point to 3D segment distance, Q8.8
// Projects the point onto the segment with the parameter clamped to [0,1]
// and returns distance to the projection and distance along the segment.
// ----------------------------------------------------------------------------
module point_segment_distance_3d (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [psd_pkg::COORD_W-1:0]  point_x,
    input  logic signed [psd_pkg::COORD_W-1:0]  point_y,
    input  logic signed [psd_pkg::COORD_W-1:0]  point_z,
    input  logic signed [psd_pkg::COORD_W-1:0]  start_x,
    input  logic signed [psd_pkg::COORD_W-1:0]  start_y,
    input  logic signed [psd_pkg::COORD_W-1:0]  start_z,
    input  logic signed [psd_pkg::COORD_W-1:0]  end_x,
    input  logic signed [psd_pkg::COORD_W-1:0]  end_y,
    input  logic signed [psd_pkg::COORD_W-1:0]  end_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [psd_pkg::OUT_W-1:0]           distance,
    output logic [psd_pkg::OUT_W-1:0]           along_distance,
    output logic                                degenerate
);

    localparam int SW = psd_pkg::SQ_W;

    logic              en;
    logic              front_valid;
    psd_pkg::front_t   front_data;
    logic              qa_valid, qb_valid;
    logic [SW-1:0]     qa, qb;

    psd_pkg::side_t    side_reg [psd_pkg::DIV_LAT];
    psd_pkg::side_t    side_in, side_out;

    logic              sel_vld_reg;
    logic [SW-1:0]     dist_sq_reg, along_sq_reg;
    logic [psd_pkg::SQRT_LAT:0] dgn_reg;

    logic              ra_valid, rb_valid;

    // whole pipeline advances unless a finished result is held
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    psd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .end_x     (end_x),
        .end_y     (end_y),
        .end_z     (end_z),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    // dot^2 / l2 for the along distance
    psd_div u_div_along (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .num       (front_data.d2),
        .den       (front_data.l2),
        .out_valid (qa_valid),
        .quo       (qa)
    );

    // perpendicular distance squared
    psd_div u_div_perp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .num       (front_data.num),
        .den       (front_data.l2),
        .out_valid (qb_valid),
        .quo       (qb)
    );

    // carry class and squares alongside the dividers
    always_comb
    begin
        side_in.cls = front_data.cls;
        side_in.l2  = front_data.l2;
        side_in.pv2 = front_data.pv2;
        side_in.pw2 = front_data.pw2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < psd_pkg::DIV_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    assign side_out = side_reg[psd_pkg::DIV_LAT-1];

    // pick the squared results for the projection case
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_vld_reg <= 1'b0;
        else if (en)
            sel_vld_reg <= qa_valid && qb_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (side_out.cls.degen || side_out.cls.pre_start)
            begin
                dist_sq_reg  <= side_out.pv2;
                along_sq_reg <= '0;
            end
            else if (side_out.cls.past)
            begin
                dist_sq_reg  <= side_out.pw2;
                along_sq_reg <= side_out.l2;
            end
            else
            begin
                dist_sq_reg  <= qb;
                along_sq_reg <= qa;
            end
            dgn_reg <= {dgn_reg[psd_pkg::SQRT_LAT-1:0], side_out.cls.degen};
        end
    end

    psd_sqrt u_sqrt_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sel_vld_reg),
        .radicand  (dist_sq_reg),
        .out_valid (ra_valid),
        .root      (distance)
    );

    psd_sqrt u_sqrt_along (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sel_vld_reg),
        .radicand  (along_sq_reg),
        .out_valid (rb_valid),
        .root      (along_distance)
    );

    assign out_valid  = ra_valid && rb_valid;
    assign degenerate = dgn_reg[psd_pkg::SQRT_LAT];

    // a degenerate segment has no along distance
    a_degen_along: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (along_distance == '0))
        else $error("degenerate result with nonzero along distance");

    // both root pipelines stay in step
    a_roots_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ra_valid == rb_valid)
        else $error("root pipelines out of step");

    // a held result keeps its valid bit through the stall
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> out_valid)
        else $error("held result lost");

endmodule

// ----- bench/tb_point_segment_distance_3d.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_segment_distance_3d: self-checking bench for the 3D distance block
// A directed table is followed by 2000 random queries. Typed rows carry their
// own answer; every other transfer is predicted with exact wide integer math.
// The sender idles and the receiver stalls at random, and results are compared
// in order, field by field.
module tb_point_segment_distance_3d;

    localparam int RAND_ITEMS  = 2000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 80;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [psd_pkg::COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t px, py, pz;
        coord_t sx, sy, sz;
        coord_t ex, ey, ez;
    } query_t;

    typedef struct packed {
        logic [psd_pkg::OUT_W-1:0] dist_val;
        logic [psd_pkg::OUT_W-1:0] along;
        logic                      degen;
    } answer_t;

    typedef struct {
        query_t  q;
        logic    typed;
        answer_t ans;
        logic    drain;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    query_t cur;
    logic out_valid;
    logic out_stall;
    logic [psd_pkg::OUT_W-1:0] distance;
    logic [psd_pkg::OUT_W-1:0] along_distance;
    logic degenerate;

    row_t    rows[$];
    answer_t pending[$];
    int      row_idx;
    int      accepted;
    int      errors;
    int      cycles;
    logic    cur_typed;
    answer_t cur_ans;

    point_segment_distance_3d u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .point_x        (cur.px),
        .point_y        (cur.py),
        .point_z        (cur.pz),
        .start_x        (cur.sx),
        .start_y        (cur.sy),
        .start_z        (cur.sz),
        .end_x          (cur.ex),
        .end_y          (cur.ey),
        .end_z          (cur.ez),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .distance       (distance),
        .along_distance (along_distance),
        .degenerate     (degenerate)
    );

    // floor of the square root
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] sum_sq(input longint a, input longint b, input longint c);
        return 64'(a * a) + 64'(b * b) + 64'(c * c);
    endfunction

    // clamped projection of the point onto the segment
    function automatic answer_t project_distance(input query_t q);
        longint pvx, pvy, pvz, wvx, wvy, wvz, dot;
        logic [63:0] l2, pv2, dist_root, along;
        logic [127:0] d2, num;
        answer_t a;
        pvx = longint'(q.px) - longint'(q.sx);
        pvy = longint'(q.py) - longint'(q.sy);
        pvz = longint'(q.pz) - longint'(q.sz);
        wvx = longint'(q.ex) - longint'(q.sx);
        wvy = longint'(q.ey) - longint'(q.sy);
        wvz = longint'(q.ez) - longint'(q.sz);
        dot = pvx * wvx + pvy * wvy + pvz * wvz;
        l2 = sum_sq(wvx, wvy, wvz);
        pv2 = sum_sq(pvx, pvy, pvz);
        a.degen = (l2 == 0);
        if (l2 == 0 || dot <= 0)
        begin
            dist_root = floor_sqrt(pv2);
            along = 0;
        end
        else if (64'(dot) >= l2)
        begin
            dist_root = floor_sqrt(sum_sq(longint'(q.px) - longint'(q.ex),
                                          longint'(q.py) - longint'(q.ey),
                                          longint'(q.pz) - longint'(q.ez)));
            along = floor_sqrt(l2);
        end
        else
        begin
            d2 = 128'(64'(dot)) * 128'(64'(dot));
            num = 128'(pv2) * 128'(l2) - d2;
            along = floor_sqrt(64'(d2 / 128'(l2)));
            dist_root = floor_sqrt(64'(num / 128'(l2)));
        end
        a.dist_val = dist_root[psd_pkg::OUT_W-1:0];
        a.along = along[psd_pkg::OUT_W-1:0];
        return a;
    endfunction

    function automatic query_t mk(input int px, py, pz, sx, sy, sz, ex, ey, ez);
        query_t q;
        q = '{coord_t'(px), coord_t'(py), coord_t'(pz), coord_t'(sx), coord_t'(sy),
              coord_t'(sz), coord_t'(ex), coord_t'(ey), coord_t'(ez)};
        return q;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'(-32768);
            1: return coord_t'(32767);
            2: return coord_t'($urandom_range(0, 3) - 1);
            3: return coord_t'($urandom_range(0, 4096) - 2048);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic add_row(input query_t q, input logic typed, input answer_t ans,
                           input logic drain);
        row_t r;
        r.q = q;
        r.typed = typed;
        r.ans = ans;
        r.drain = drain;
        rows.push_back(r);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, accepted);
    endtask

    // clock
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // build the stimulus table, then wait for the end
    initial
    begin
        query_t q;
        int kind;
        int d;
        rst_n = 0;
        // zero-length segment at the origin
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{17'd0, 17'd0, 1'b1}, 0);
        // widest degenerate case
        add_row(mk(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767),
                1, '{17'd113509, 17'd0, 1'b1}, 0);
        // projection before start
        add_row(mk(-256, 0, 0, 0, 0, 0, 256, 0, 0), 1, '{17'd256, 17'd0, 1'b0}, 0);
        // projection past end
        add_row(mk(768, 0, 0, 0, 0, 0, 256, 0, 0), 1, '{17'd512, 17'd256, 1'b0}, 0);
        // interior projection on the segment
        add_row(mk(256, 0, 0, 0, 0, 0, 512, 0, 0), 1, '{17'd0, 17'd256, 1'b0}, 0);
        add_row(mk(256, 300, -77, 0, 0, 0, 512, 0, 0), 0, '0, 0);
        // extreme segment lengths and corners
        add_row(mk(0, 0, 0, -32768, -32768, -32768, 32767, 32767, 32767), 0, '0, 0);
        add_row(mk(32767, -32768, 32767, -32768, -32768, -32768, 32767, 32767, 32767),
                0, '0, 0);
        add_row(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768),
                0, '0, 0);
        add_row(mk(32767, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 32767),
                0, '0, 0);
        add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767),
                0, '0, 0);
        // unit step segment with the point at the ends, a diagonal step, a zero-length segment
        add_row(mk(1, 0, 0, 0, 0, 0, 1, 0, 0), 0, '0, 0);
        add_row(mk(0, 0, 0, 0, 0, 0, 1, 0, 0), 0, '0, 0);
        add_row(mk(5, -3, 7, 0, 0, 0, 1, 1, 1), 0, '0, 0);
        add_row(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1), 0, '0, 0);
        // perpendicular point, dot exactly zero
        add_row(mk(0, 1000, 0, 0, 0, 0, 1000, 0, 0), 0, '0, 0);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            kind = $urandom_range(0, 9);
            q = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
            if (kind < 2)
                q = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            else if (kind == 2)
                {q.ex, q.ey, q.ez} = {q.sx, q.sy, q.sz};
            else if (kind < 6)
            begin
                // short segment with the point nearby
                d = $urandom_range(1, 12);
                q.ex = q.sx + coord_t'($urandom_range(0, 2 << d) - (1 << d));
                q.ey = q.sy + coord_t'($urandom_range(0, 2 << d) - (1 << d));
                q.ez = q.sz + coord_t'($urandom_range(0, 2 << d) - (1 << d));
                q.px = q.sx + coord_t'($urandom_range(0, 4 << d) - (2 << d));
                q.py = q.sy + coord_t'($urandom_range(0, 4 << d) - (2 << d));
                q.pz = q.sz + coord_t'($urandom_range(0, 4 << d) - (2 << d));
            end
            add_row(q, 0, '0, (i == RAND_ITEMS / 2));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1;

        wait (row_idx == rows.size() && !in_valid);
        wait (pending.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // sender: bursts of transfers with gaps between them
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            cur <= '0;
            cur_typed <= 0;
            cur_ans <= '0;
            row_idx = 0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            // log the transfer that completes at this edge
            if (in_valid && !in_stall)
                pending.push_back(cur_typed ? cur_ans : project_distance(cur));
            // hold a stalled payload, otherwise pick the next one
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 0;
                end
                else if (row_idx < rows.size()
                         && !(rows[row_idx].drain && pending.size() != 0))
                begin
                    in_valid <= 1;
                    cur <= rows[row_idx].q;
                    cur_typed <= rows[row_idx].typed;
                    cur_ans <= rows[row_idx].ans;
                    row_idx++;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // receiver: stall pattern in phases, plus one long hold-off
    int phase_left;
    int mode;
    int hold_left;
    logic held;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            phase_left = 0;
            mode = 0;
            hold_left = 0;
            held = 0;
        end
        else
        begin
            if (!held && row_idx >= HOLD_AT)
            begin
                held = 1;
                hold_left = HOLD_CYCLES;
            end
            if (phase_left == 0)
            begin
                mode = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 300);
            end
            phase_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1;
            end
            else
                case (mode)
                    0: out_stall <= 0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= (phase_left % 4 == 0);
                endcase
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            accepted++;
            if (pending.size() == 0)
                report("unexpected result", distance, -1);
            else
            begin
                want = pending.pop_front();
                if (distance !== want.dist_val)
                    report("distance", distance, want.dist_val);
                if (along_distance !== want.along)
                    report("along_distance", along_distance, want.along);
                if (degenerate !== want.degen)
                    report("degenerate", degenerate, want.degen);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        accepted = 0;
    end

endmodule
